// File: src/rnwc_pkg.sv
// shared constants and types for the ray nearest wall clip unit
`timescale 1ns / 1ps
package rnwc_pkg;

    // defaults for the top level parameters
    localparam int COORD_WIDTH_DEF = 24;
    localparam int RAY_LENGTH_DEF  = 3000;

    // direction components are signed q1.14
    localparam int DIR_WIDTH = 16;

    // right shift that takes a q1.14 times integer offset to q.8
    localparam int OFFSET_SHIFT = 6;

    // back unit sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_NORM,
        ST_CHK,
        ST_SCL,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } t_back_state;

endpackage

// File: src/rnwc_fifo.sv
// two entry queue between the front and back units
`timescale 1ns / 1ps
module rnwc_fifo
    import rnwc_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              w_push;
    logic              w_pop;

    // handshake on both sides
    assign o_stall = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;
    assign o_data  = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// File: src/rnwc_front.sv
// front unit: takes beats, works out initial ray end points and fixed differences
`timescale 1ns / 1ps
module rnwc_front
    import rnwc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int RAY_LENGTH  = RAY_LENGTH_DEF,
    localparam int W  = COORD_WIDTH,
    localparam int DW = W + 1,
    localparam int EW = 2 + 4 * W + 4 * DW
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_first_wall,
    input  logic                        i_last_wall,
    input  logic signed [W-1:0]         i_origin_x,
    input  logic signed [W-1:0]         i_origin_y,
    input  logic signed [DIR_WIDTH-1:0] i_dir_x,
    input  logic signed [DIR_WIDTH-1:0] i_dir_y,
    input  logic signed [W-1:0]         i_wall_ax,
    input  logic signed [W-1:0]         i_wall_ay,
    input  logic signed [W-1:0]         i_wall_bx,
    input  logic signed [W-1:0]         i_wall_by,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [EW-1:0]               o_data
);

    localparam int LW = $clog2(RAY_LENGTH + 1);
    localparam int PW = DIR_WIDTH + LW + 1;
    localparam int SW = ((W > PW) ? W : PW) + 2;
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
    localparam logic signed [PW-1:0] LEN    = PW'(RAY_LENGTH);
    localparam logic signed [PW-1:0] HALF   = PW'(1 << (OFFSET_SHIFT - 1));

    logic                 r_valid;
    logic                 r_first;
    logic                 r_last;
    logic signed [W-1:0]  r_ox;
    logic signed [W-1:0]  r_oy;
    logic signed [W-1:0]  r_ax;
    logic signed [W-1:0]  r_ay;
    logic signed [W-1:0]  r_bx;
    logic signed [W-1:0]  r_by;
    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;

    logic signed [W-1:0]  w_rst_x;
    logic signed [W-1:0]  w_rst_y;
    logic signed [DW-1:0] w_d13x;
    logic signed [DW-1:0] w_d13y;
    logic signed [DW-1:0] w_d34x;
    logic signed [DW-1:0] w_d34y;

    // stage holds while the queue is full
    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;

    // register the beat and the raw direction times length products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_first <= i_first_wall;
            r_last  <= i_last_wall;
            r_ox    <= i_origin_x;
            r_oy    <= i_origin_y;
            r_ax    <= i_wall_ax;
            r_ay    <= i_wall_ay;
            r_bx    <= i_wall_bx;
            r_by    <= i_wall_by;
            r_px    <= PW'(i_dir_x) * LEN;
            r_py    <= PW'(i_dir_y) * LEN;
        end
    end

    // round the offset to q.8, add to origin and clamp
    function automatic logic signed [W-1:0] start_pt(
        input logic signed [W-1:0]  org,
        input logic signed [PW-1:0] prod
    );
        logic signed [PW-1:0] mag;
        logic signed [PW-1:0] rnd;
        logic signed [PW-1:0] off;
        logic signed [SW-1:0] sum;
        logic signed [W-1:0]  res;
        mag = prod[PW-1] ? -prod : prod;
        rnd = (mag + HALF) >>> OFFSET_SHIFT;
        off = prod[PW-1] ? -rnd : rnd;
        sum = SW'(org) + SW'(off);
        if (sum > SAT_HI) begin
            res = SAT_HI[W-1:0];
        end else if (sum < SAT_LO) begin
            res = SAT_LO[W-1:0];
        end else begin
            res = sum[W-1:0];
        end
        return res;
    endfunction

    assign w_rst_x = start_pt(r_ox, r_px);
    assign w_rst_y = start_pt(r_oy, r_py);

    // differences that do not depend on the running end point
    assign w_d13x = DW'(r_ox) - DW'(r_ax);
    assign w_d13y = DW'(r_oy) - DW'(r_ay);
    assign w_d34x = DW'(r_ax) - DW'(r_bx);
    assign w_d34y = DW'(r_ay) - DW'(r_by);

    assign o_data = {r_first, r_last, r_ox, r_oy, w_rst_x, w_rst_y,
                     w_d13x, w_d13y, w_d34x, w_d34y};

endmodule

// File: src/rnwc_back.sv
// back unit: ray against wall test, exact scaling and divide, result register
`timescale 1ns / 1ps
module rnwc_back
    import rnwc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int W  = COORD_WIDTH,
    localparam int DW = W + 1,
    localparam int EW = 2 + 4 * W + 4 * DW
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [EW-1:0]       i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [W-1:0] o_hit_x,
    output logic signed [W-1:0] o_hit_y
);

    localparam int MW  = W + 2;
    localparam int PRW = 2 * MW;
    localparam int AW  = 2 * W + 3;
    localparam int NW  = 3 * W + 3;
    localparam int SCW = $clog2(W + 1);
    localparam logic [SCW-1:0] MUL_LAST = SCW'(6);
    localparam logic [SCW-1:0] SCL_LAST = SCW'(5);
    localparam logic [SCW-1:0] DIV_LAST = SCW'(W - 1);
    localparam logic signed [W+1:0] SAT_HI = {3'b000, {(W - 1){1'b1}}};
    localparam logic signed [W+1:0] SAT_LO = {3'b111, {(W - 1){1'b0}}};

    // queue entry fields
    logic                 q_first;
    logic                 q_last;
    logic signed [W-1:0]  q_ox;
    logic signed [W-1:0]  q_oy;
    logic signed [W-1:0]  q_rst_x;
    logic signed [W-1:0]  q_rst_y;
    logic signed [DW-1:0] q_d13x;
    logic signed [DW-1:0] q_d13y;
    logic signed [DW-1:0] q_d34x;
    logic signed [DW-1:0] q_d34y;

    assign {q_first, q_last, q_ox, q_oy, q_rst_x, q_rst_y,
            q_d13x, q_d13y, q_d34x, q_d34y} = i_data;

    t_back_state          r_state;
    t_back_state          n_state;
    logic [SCW-1:0]       r_step;
    logic                 r_last;
    logic signed [W-1:0]  r_ox;
    logic signed [W-1:0]  r_oy;
    logic signed [W-1:0]  r_end_x;
    logic signed [W-1:0]  r_end_y;
    logic signed [DW-1:0] r_d12x;
    logic signed [DW-1:0] r_d12y;
    logic signed [DW-1:0] r_d13x;
    logic signed [DW-1:0] r_d13y;
    logic signed [DW-1:0] r_d34x;
    logic signed [DW-1:0] r_d34y;
    logic signed [AW-1:0] r_den;
    logic signed [AW-1:0] r_tn;
    logic signed [AW-1:0] r_un;
    logic signed [PRW-1:0] r_prod;
    logic [NW-1:0]        r_numx;
    logic [NW-1:0]        r_numy;
    logic [NW-1:0]        r_remx;
    logic [NW-1:0]        r_remy;
    logic [NW-1:0]        r_dsh;
    logic [W-1:0]         r_qx;
    logic [W-1:0]         r_qy;
    logic                 r_out_valid;
    logic signed [W-1:0]  r_hit_x;
    logic signed [W-1:0]  r_hit_y;

    logic                 w_take;
    logic                 w_can_emit;
    logic signed [W-1:0]  w_p2x;
    logic signed [W-1:0]  w_p2y;
    logic signed [MW-1:0] w_ma;
    logic signed [MW-1:0] w_mb;
    logic signed [PRW-1:0] w_mprod;
    logic signed [AW-1:0] w_p;
    logic signed [DW-1:0] w_negx;
    logic signed [DW-1:0] w_negy;
    logic [W-1:0]         w_mx;
    logic [W-1:0]         w_my;
    logic                 w_ok;
    logic                 w_gex;
    logic                 w_gey;
    logic [NW-1:0]        w_nprod;
    logic signed [W-1:0]  w_newx;
    logic signed [W-1:0]  w_newy;

    assign w_take     = i_valid && (r_state == ST_IDLE);
    assign w_can_emit = !r_out_valid || !i_stall;

    // end point at the start of the test
    assign w_p2x = q_first ? q_rst_x : r_end_x;
    assign w_p2y = q_first ? q_rst_y : r_end_y;

    // magnitudes of the end minus origin deltas
    assign w_negx = -r_d12x;
    assign w_negy = -r_d12y;
    assign w_mx   = r_d12x[DW-1] ? w_negx[W-1:0] : r_d12x[W-1:0];
    assign w_my   = r_d12y[DW-1] ? w_negy[W-1:0] : r_d12y[W-1:0];

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == ST_MUL) begin
            case (r_step)
                SCW'(0): begin w_ma = MW'(r_d12x); w_mb = MW'(r_d34y); end
                SCW'(1): begin w_ma = MW'(r_d12y); w_mb = MW'(r_d34x); end
                SCW'(2): begin w_ma = MW'(r_d13x); w_mb = MW'(r_d34y); end
                SCW'(3): begin w_ma = MW'(r_d13y); w_mb = MW'(r_d34x); end
                SCW'(4): begin w_ma = MW'(r_d12x); w_mb = MW'(r_d13y); end
                SCW'(5): begin w_ma = MW'(r_d12y); w_mb = MW'(r_d13x); end
                default: begin w_ma = '0; w_mb = '0; end
            endcase
        end else if (r_state == ST_SCL) begin
            case (r_step)
                SCW'(0): begin w_ma = {2'b00, r_tn[W-1:0]}; w_mb = {2'b00, w_mx}; end
                SCW'(1): begin w_ma = {1'b0, r_tn[2*W:W]};  w_mb = {2'b00, w_mx}; end
                SCW'(2): begin w_ma = {2'b00, r_tn[W-1:0]}; w_mb = {2'b00, w_my}; end
                SCW'(3): begin w_ma = {1'b0, r_tn[2*W:W]};  w_mb = {2'b00, w_my}; end
                default: begin w_ma = '0; w_mb = '0; end
            endcase
        end
    end

    // full width signed product
    assign w_mprod = w_ma * w_mb;

    assign w_p     = r_prod[AW-1:0];
    assign w_nprod = NW'(unsigned'(r_prod));

    // strict crossing on both segments
    assign w_ok = (r_tn > 0) && (r_tn < r_den) && (r_un > 0) && (r_un < r_den);

    // restoring divide compares
    assign w_gex = (r_remx >= r_dsh);
    assign w_gey = (r_remy >= r_dsh);

    // signed offset back onto the origin, clamped
    function automatic logic signed [W-1:0] place(
        input logic signed [W-1:0] org,
        input logic                neg,
        input logic [W-1:0]        q
    );
        logic signed [W+1:0] qs;
        logic signed [W+1:0] sum;
        logic signed [W-1:0] res;
        qs  = {2'b00, q};
        sum = (W + 2)'(org) + (neg ? -qs : qs);
        if (sum > SAT_HI) begin
            res = SAT_HI[W-1:0];
        end else if (sum < SAT_LO) begin
            res = SAT_LO[W-1:0];
        end else begin
            res = sum[W-1:0];
        end
        return res;
    endfunction

    // end minus origin is the negated d12, so a positive d12 means a negative step
    assign w_newx = place(r_ox, (r_d12x > 0), r_qx);
    assign w_newy = place(r_oy, (r_d12y > 0), r_qy);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_MUL;
            ST_MUL:  if (r_step == MUL_LAST) n_state = ST_NORM;
            ST_NORM: n_state = (r_den == 0) ? ST_DONE : ST_CHK;
            ST_CHK:  n_state = w_ok ? ST_SCL : ST_DONE;
            ST_SCL:  if (r_step == SCL_LAST) n_state = ST_DIV;
            ST_DIV:  if (r_step == DIV_LAST) n_state = ST_FIN;
            ST_FIN:  n_state = ST_DONE;
            ST_DONE: if (!r_last || w_can_emit) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_stall = (r_state != ST_IDLE);
        o_valid = r_out_valid;
        o_hit_x = r_hit_x;
        o_hit_y = r_hit_y;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_end_x     <= '0;
            r_end_y     <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_step <= '0;
            end else begin
                r_step <= r_step + SCW'(1);
            end
            if (w_take) begin
                r_end_x <= w_p2x;
                r_end_y <= w_p2y;
            end else if (r_state == ST_FIN) begin
                r_end_x <= w_newx;
                r_end_y <= w_newy;
            end
            if (r_state == ST_DONE && r_last && w_can_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_mprod;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    r_last <= q_last;
                    r_ox   <= q_ox;
                    r_oy   <= q_oy;
                    r_d12x <= DW'(q_ox) - DW'(w_p2x);
                    r_d12y <= DW'(q_oy) - DW'(w_p2y);
                    r_d13x <= q_d13x;
                    r_d13y <= q_d13y;
                    r_d34x <= q_d34x;
                    r_d34y <= q_d34y;
                end
            end
            ST_MUL: begin
                // product of the previous step lands here
                case (r_step)
                    SCW'(1): r_den <= w_p;
                    SCW'(2): r_den <= r_den - w_p;
                    SCW'(3): r_tn  <= w_p;
                    SCW'(4): r_tn  <= r_tn - w_p;
                    SCW'(5): r_un  <= -w_p;
                    SCW'(6): r_un  <= r_un + w_p;
                    default: ;
                endcase
            end
            ST_NORM: begin
                if (r_den[AW-1]) begin
                    r_den <= -r_den;
                    r_tn  <= -r_tn;
                    r_un  <= -r_un;
                end
            end
            ST_SCL: begin
                // tn times delta from two partial products, then seed the divide
                case (r_step)
                    SCW'(1): r_numx <= w_nprod;
                    SCW'(2): r_numx <= r_numx + (w_nprod << W);
                    SCW'(3): r_numy <= w_nprod;
                    SCW'(4): r_numy <= r_numy + (w_nprod << W);
                    SCW'(5): begin
                        r_remx <= (r_numx << 1) + NW'(unsigned'(r_den));
                        r_remy <= (r_numy << 1) + NW'(unsigned'(r_den));
                        r_dsh  <= NW'(unsigned'(r_den)) << W;
                    end
                    default: ;
                endcase
            end
            ST_DIV: begin
                // one quotient bit per lane each cycle
                if (w_gex) r_remx <= r_remx - r_dsh;
                if (w_gey) r_remy <= r_remy - r_dsh;
                r_qx  <= {r_qx[W-2:0], w_gex};
                r_qy  <= {r_qy[W-2:0], w_gey};
                r_dsh <= r_dsh >> 1;
            end
            ST_DONE: begin
                if (r_last && w_can_emit) begin
                    r_hit_x <= r_end_x;
                    r_hit_y <= r_end_y;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: src/ray_nearest_wall_clip_unit.sv
// top level of the ray nearest wall clip unit
`timescale 1ns / 1ps
// Each beat is one ray against wall test; a beat with first_wall set restarts
// the ray at origin plus direction times RAY_LENGTH, and a beat with last_wall
// set gives one beat out with the nearest crossing found. The front unit takes
// a beat every cycle, unless the queue is full, into a two entry queue; the back
// unit works one test at a time through a single shared multiplier and a
// bit-serial divider that gives one quotient bit per divider cycle.
module ray_nearest_wall_clip_unit
    import rnwc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int RAY_LENGTH  = RAY_LENGTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_first_wall,
    input  logic                          i_last_wall,
    input  logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [DIR_WIDTH-1:0]   i_dir_x,
    input  logic signed [DIR_WIDTH-1:0]   i_dir_y,
    input  logic signed [COORD_WIDTH-1:0] i_wall_ax,
    input  logic signed [COORD_WIDTH-1:0] i_wall_ay,
    input  logic signed [COORD_WIDTH-1:0] i_wall_bx,
    input  logic signed [COORD_WIDTH-1:0] i_wall_by,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_hit_x,
    output logic signed [COORD_WIDTH-1:0] o_hit_y
);

    localparam int EW = 2 + 4 * COORD_WIDTH + 4 * (COORD_WIDTH + 1);

    logic          f_valid;
    logic          f_stall;
    logic [EW-1:0] f_data;
    logic          q_valid;
    logic          q_stall;
    logic [EW-1:0] q_data;

    // front: capture and prepare
    rnwc_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .RAY_LENGTH  (RAY_LENGTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_first_wall (i_first_wall),
        .i_last_wall  (i_last_wall),
        .i_origin_x   (i_origin_x),
        .i_origin_y   (i_origin_y),
        .i_dir_x      (i_dir_x),
        .i_dir_y      (i_dir_y),
        .i_wall_ax    (i_wall_ax),
        .i_wall_ay    (i_wall_ay),
        .i_wall_bx    (i_wall_bx),
        .i_wall_by    (i_wall_by),
        .o_valid      (f_valid),
        .i_stall      (f_stall),
        .o_data       (f_data)
    );

    // queue between the two units
    rnwc_fifo #(
        .DATA_W (EW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_stall (f_stall),
        .i_data  (f_data),
        .o_valid (q_valid),
        .i_stall (q_stall),
        .o_data  (q_data)
    );

    // back: wall test and result
    rnwc_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_stall (q_stall),
        .i_data  (q_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_hit_x (o_hit_x),
        .o_hit_y (o_hit_y)
    );

endmodule

// File: tb/tb.sv
// self-checking testbench for the ray nearest wall clip unit
`timescale 1ns / 1ps
module tb;
    import rnwc_pkg::*;

    localparam int CW        = COORD_WIDTH_DEF;
    localparam int RAY_LEN   = RAY_LENGTH_DEF;
    localparam int LIMIT     = 1000000;
    localparam int TAIL      = 80;
    localparam int N_RANDOM  = 1420;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic                    first_wall;
        logic                    last_wall;
        logic signed [CW-1:0]    origin_x;
        logic signed [CW-1:0]    origin_y;
        logic signed [DIR_WIDTH-1:0] dir_x;
        logic signed [DIR_WIDTH-1:0] dir_y;
        logic signed [CW-1:0]    wall_ax;
        logic signed [CW-1:0]    wall_ay;
        logic signed [CW-1:0]    wall_bx;
        logic signed [CW-1:0]    wall_by;
    } t_wall_beat;

    typedef struct {
        logic signed [CW-1:0] hit_x;
        logic signed [CW-1:0] hit_y;
    } t_hit;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic                        i_first_wall;
    logic                        i_last_wall;
    logic signed [CW-1:0]        i_origin_x;
    logic signed [CW-1:0]        i_origin_y;
    logic signed [DIR_WIDTH-1:0] i_dir_x;
    logic signed [DIR_WIDTH-1:0] i_dir_y;
    logic signed [CW-1:0]        i_wall_ax;
    logic signed [CW-1:0]        i_wall_ay;
    logic signed [CW-1:0]        i_wall_bx;
    logic signed [CW-1:0]        i_wall_by;
    logic                        o_valid;
    logic                        i_stall;
    logic signed [CW-1:0]        o_hit_x;
    logic signed [CW-1:0]        o_hit_y;

    // predictor state and bookkeeping
    logic signed [CW-1:0] ray_end_x;
    logic signed [CW-1:0] ray_end_y;
    t_hit                 hits_due[$];
    int                   n_errors;
    int                   n_beats;
    int                   n_hits_seen;
    int                   cycle_count;
    int                   hold_cycles;
    bit                   calm;

    ray_nearest_wall_clip_unit u_dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // clamp to the signed coordinate range
    function automatic logic signed [CW-1:0] clamp_coord(t_wide v);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[CW-1:0];
        if (v < lo) return lo[CW-1:0];
        return v[CW-1:0];
    endfunction

    // direction times ray length, taken to q.8, rounded half away from zero
    function automatic t_wide reach_offset(logic signed [DIR_WIDTH-1:0] d);
        t_wide p;
        t_wide m;
        p = t_wide'(d) * RAY_LEN;
        m = ((p < 0 ? -p : p) + 32) >>> OFFSET_SHIFT;
        return p < 0 ? -m : m;
    endfunction

    // round(tn * diff / den) half away from zero, den positive
    function automatic t_wide crossing_step(t_wide tn, t_wide diff, t_wide den);
        t_wide mag;
        t_wide q;
        mag = diff < 0 ? -diff : diff;
        q = (2 * tn * mag + den) / (2 * den);
        return diff < 0 ? -q : q;
    endfunction

    // one ray against wall test; returns 1 when a hit point is emitted
    function automatic bit clip_ray(t_wall_beat b, output t_hit h);
        t_wide p1x, p1y, p2x, p2y, p3x, p3y, p4x, p4y;
        t_wide den, tn, un;
        p1x = b.origin_x;
        p1y = b.origin_y;
        if (b.first_wall) begin
            ray_end_x = clamp_coord(p1x + reach_offset(b.dir_x));
            ray_end_y = clamp_coord(p1y + reach_offset(b.dir_y));
        end
        p2x = ray_end_x;
        p2y = ray_end_y;
        p3x = b.wall_ax;
        p3y = b.wall_ay;
        p4x = b.wall_bx;
        p4y = b.wall_by;
        den = (p1x - p2x) * (p3y - p4y) - (p1y - p2y) * (p3x - p4x);
        tn  = (p1x - p3x) * (p3y - p4y) - (p1y - p3y) * (p3x - p4x);
        un  = -((p1x - p2x) * (p1y - p3y) - (p1y - p2y) * (p1x - p3x));
        if (den != 0) begin
            if (den < 0) begin
                den = -den;
                tn  = -tn;
                un  = -un;
            end
            if (tn > 0 && tn < den && un > 0 && un < den) begin
                ray_end_x = clamp_coord(p1x + crossing_step(tn, p2x - p1x, den));
                ray_end_y = clamp_coord(p1y + crossing_step(tn, p2y - p1y, den));
            end
        end
        h.hit_x = ray_end_x;
        h.hit_y = ray_end_y;
        return b.last_wall;
    endfunction

    // send one beat and predict its outcome once accepted
    task automatic send_beat(t_wall_beat b);
        t_hit h;
        i_valid      <= 1'b1;
        i_first_wall <= b.first_wall;
        i_last_wall  <= b.last_wall;
        i_origin_x   <= b.origin_x;
        i_origin_y   <= b.origin_y;
        i_dir_x      <= b.dir_x;
        i_dir_y      <= b.dir_y;
        i_wall_ax    <= b.wall_ax;
        i_wall_ay    <= b.wall_ay;
        i_wall_bx    <= b.wall_bx;
        i_wall_by    <= b.wall_by;
        do @(posedge i_clk); while (o_stall);
        n_beats++;
        if (clip_ray(b, h)) hits_due = {hits_due, h};
        // random gap before the next beat
        if (!calm && $urandom_range(0, 99) < 26) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic t_wall_beat mk_beat(int f, int l, int ox, int oy, int dx, int dy,
                                           int ax, int ay, int bx, int by);
        t_wall_beat b;
        b.first_wall = f[0];
        b.last_wall  = l[0];
        b.origin_x   = CW'(ox);
        b.origin_y   = CW'(oy);
        b.dir_x      = DIR_WIDTH'(dx);
        b.dir_y      = DIR_WIDTH'(dy);
        b.wall_ax    = CW'(ax);
        b.wall_ay    = CW'(ay);
        b.wall_bx    = CW'(bx);
        b.wall_by    = CW'(by);
        return b;
    endfunction

    function automatic int srand_range(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // random beat: mostly a local scene around the origin, some full range noise
    function automatic t_wall_beat rand_beat(bit f, bit l, int ox, int oy, int dx, int dy);
        t_wall_beat b;
        if ($urandom_range(0, 99) < 12) begin
            b = mk_beat(f, l, $urandom, $urandom, srand_range(16384), srand_range(16384),
                        $urandom, $urandom, $urandom, $urandom);
        end else begin
            b = mk_beat(f, l, ox, oy, dx, dy,
                        ox + srand_range(1 << 20), oy + srand_range(1 << 20),
                        ox + srand_range(1 << 20), oy + srand_range(1 << 20));
        end
        return b;
    endfunction

    // check each result beat, and drive the output stall
    always @(posedge i_clk) begin
        t_hit e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_hits_seen++;
            if (hits_due.size() == 0) begin
                $error("unexpected result beat hit_x=%0d hit_y=%0d", o_hit_x, o_hit_y);
                n_errors++;
            end else begin
                e = hits_due.pop_front();
                if (o_hit_x !== e.hit_x) begin
                    $error("hit_x expected %0d actual %0d", e.hit_x, o_hit_x);
                    n_errors++;
                end
                if (o_hit_y !== e.hit_y) begin
                    $error("hit_y expected %0d actual %0d", e.hit_y, o_hit_y);
                    n_errors++;
                end
            end
        end
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(0, 99) < 26);
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // test tasks

    // after reset the stored end point is zero
    task automatic test_no_first();
        send_beat(mk_beat(0, 1, -5000, 3000, 0, 0, -1000, -4000, -1000, 4000));
        send_beat(mk_beat(0, 1, 200, 200, 16384, 0, 100, -300, 100, 300));
    endtask

    task automatic test_simple_hits();
        send_beat(mk_beat(1, 0, 0, 0, 16384, 0, 1000, -1000, 1000, 1000));
        send_beat(mk_beat(0, 0, 0, 0, 16384, 0, 500, -1000, 500, 1000));
        send_beat(mk_beat(0, 1, 0, 0, 16384, 0, 800, -1000, 800, 1000));
        send_beat(mk_beat(1, 1, 1000, -2000, -11585, 11585, -3000, 0, 3000, 1));
        send_beat(mk_beat(1, 1, 77, 33, 0, -16384, -900, -51, 901, -50));
    endtask

    // parallel and degenerate walls leave the end point alone
    task automatic test_parallel();
        send_beat(mk_beat(1, 1, 0, 0, 16384, 0, 0, 500, 1000, 500));
        send_beat(mk_beat(1, 1, 0, 0, 0, 16384, 700, 700, 700, 700));
        send_beat(mk_beat(1, 1, 0, 0, 16384, 0, 100, 0, 900, 0));
    endtask

    // crossings that only touch at an end do not count
    task automatic test_touch();
        send_beat(mk_beat(1, 1, 0, 0, 16384, 0, 1000, 0, 1000, 1000));
        send_beat(mk_beat(1, 1, 0, 0, 16384, 0, 1000, -1000, 1000, 0));
        send_beat(mk_beat(1, 1, 0, 0, 16384, 0, 0, -1000, 0, 1000));
        send_beat(mk_beat(1, 1, 0, 0, 16384, 0, 768000, -1000, 768000, 1000));
    endtask

    // field extremes and ray ends that saturate
    task automatic test_extremes();
        send_beat(mk_beat(1, 1, 8388607, 8388607, 16384, 16384,
                          -8388608, 8388607, 8388607, -8388608));
        send_beat(mk_beat(1, 1, -8388608, -8388608, -16384, -16384,
                          8388607, -8388608, -8388608, 8388607));
        send_beat(mk_beat(1, 1, 8388000, 0, 16384, 16384, 8388500, -100, 8388500, 8388607));
        send_beat(mk_beat(1, 1, -8388608, 8388607, 16384, -16384,
                          -8388608, -8388608, 8388607, 8388607));
        send_beat(mk_beat(1, 1, 0, 0, -16384, 16384, -1, -1, -1, -1));
    endtask

    // beats without last_wall give nothing
    task automatic test_no_result();
        send_beat(mk_beat(1, 0, 10, 10, 0, 16384, -500, 300, 500, 300));
        send_beat(mk_beat(0, 0, 10, 10, 0, 16384, -500, 200, 500, 200));
        send_beat(mk_beat(0, 1, 10, 10, 0, 16384, -500, 900, 500, 900));
    endtask

    // random scenes: runs of walls for one ray, some broken runs
    task automatic test_random_scenes(int n);
        int sent;
        int len;
        int ox, oy, dx, dy;
        bit f, l;
        sent = 0;
        while (sent < n) begin
            len = $urandom_range(1, 6);
            ox = srand_range(1 << 22);
            oy = srand_range(1 << 22);
            dx = srand_range(16384);
            dy = srand_range(16384);
            calm = (sent > n / 3) && (sent < n / 3 + 150);
            for (int k = 0; k < len; k++) begin
                f = (k == 0);
                l = (k == len - 1);
                if ($urandom_range(0, 99) < 8) f = ~f;
                if ($urandom_range(0, 99) < 8) l = ~l;
                send_beat(rand_beat(f, l, ox, oy, dx, dy));
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        hold_cycles = 400;
        for (int k = 0; k < 30; k++) begin
            send_beat(rand_beat(1, 1, srand_range(1 << 20), srand_range(1 << 20),
                                srand_range(16384), srand_range(16384)));
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_first_wall = 1'b0;
        i_last_wall  = 1'b0;
        i_origin_x   = '0;
        i_origin_y   = '0;
        i_dir_x      = '0;
        i_dir_y      = '0;
        i_wall_ax    = '0;
        i_wall_ay    = '0;
        i_wall_bx    = '0;
        i_wall_by    = '0;
        ray_end_x    = '0;
        ray_end_y    = '0;
        n_errors     = 0;
        n_beats      = 0;
        n_hits_seen  = 0;
        cycle_count  = 0;
        hold_cycles  = 0;
        calm         = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_first();
        test_simple_hits();
        test_parallel();
        test_touch();
        test_extremes();
        test_no_result();
        test_backpressure();
        test_random_scenes(N_RANDOM);

        i_valid <= 1'b0;
        while (hits_due.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);

        $display("covered %0d wall tests and %0d hit beats: directed cases, random scenes,",
                 n_beats, n_hits_seen);
        $display("random idling on both sides and one long output hold-off");
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/rnwc_pkg.sv
src/rnwc_fifo.sv
src/rnwc_front.sv
src/rnwc_back.sv
src/ray_nearest_wall_clip_unit.sv
tb/tb.sv
